### hw/rtl/gdad_pkg.sv
`default_nettype none
package gdad_pkg;

  // Calendar limits and lengths.
  localparam logic [13:0] MAX_YEAR  = 14'd9999;
  localparam logic [3:0]  LAST_MONTH = 4'd12;
  localparam logic [4:0]  LAST_DAY  = 5'd31;
  localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
  localparam logic [8:0]  YEAR_LEN  = 9'd365;
  localparam logic [4:0]  LEAP_FEB_LEN = 5'd29;

  // Division by 100 as a multiply by 2^19/100, exact for years up to 9999.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [6:0]  LAST_YEAR_IN_CENT = 7'd99;

  // Widths of the working registers.
  localparam int ORD_W  = 17;
  localparam int CENT_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_ORD,
    ST_YEAR,
    ST_MON,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic ord;
    logic year_step;
    logic mon_init;
    logic mon_step;
    logic set_sat;
    logic use_year;
    logic out_valid;
    logic in_ready;
  } ctl_t;

  // Flags from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic in_over;
    logic gt;
    logic year_max;
    logic month_last;
  } stat_t;

  // Length of a month, February taking the leap flag into account.
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    begin
      case (month) inside
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        4'd2:                    len = leap ? LEAP_FEB_LEN : 5'd28;
        default:                 len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // Days in the months before the given one, common year.
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    begin
      case (month)
        4'd1:    d = 9'd0;
        4'd2:    d = 9'd31;
        4'd3:    d = 9'd59;
        4'd4:    d = 9'd90;
        4'd5:    d = 9'd120;
        4'd6:    d = 9'd151;
        4'd7:    d = 9'd181;
        4'd8:    d = 9'd212;
        4'd9:    d = 9'd243;
        4'd10:   d = 9'd273;
        4'd11:   d = 9'd304;
        default: d = 9'd334;
      endcase
      return d;
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/gdad_sub.sv
`default_nettype none
module gdad_sub
  import gdad_pkg::*;
(
  input  wire logic [ORD_W-1:0] a,
  input  wire logic [8:0]       b,
  output logic [ORD_W-1:0]      diff,
  output logic                  gt
);

  logic [ORD_W:0] full;

  // One subtractor serves both the year and the month walk; the borrow
  // and a zero test give the strict comparison.
  assign full = {1'b0, a} - {{(ORD_W-8){1'b0}}, b};
  assign diff = full[ORD_W-1:0];
  assign gt   = !full[ORD_W] && (full[ORD_W-1:0] != '0);

endmodule
`default_nettype wire

### hw/rtl/gdad_seq.sv
`default_nettype none
module gdad_seq
  import gdad_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire stat_t st,
  output ctl_t       ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (st.in_fire) begin
          ctl.load   = 1'b1;
          state_next = st.in_over ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div    = 1'b1;
        state_next = ST_REM;
      end
      ST_REM: begin
        ctl.rem    = 1'b1;
        state_next = ST_ORD;
      end
      ST_ORD: begin
        ctl.ord    = 1'b1;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        ctl.use_year = 1'b1;
        if (st.gt) begin
          if (st.year_max) begin
            ctl.set_sat = 1'b1;
            state_next  = ST_DONE;
          end else begin
            ctl.year_step = 1'b1;
          end
        end else begin
          ctl.mon_init = 1'b1;
          state_next   = ST_MON;
        end
      end
      ST_MON: begin
        if (!st.month_last && st.gt) begin
          ctl.mon_step = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl.out_valid = 1'b1;
        if (st.out_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/gregorian_date_add_days.sv
// Steps: load, divide the year by 100, form the year within the century, form
//   the day of the year, then skip whole years and step through the months;
//   a start year past 9999 is answered in the cycle after the request.
// Throughput: one request at a time, the next taken in the cycle after the result is taken;
//   the year walk goes through the shared subtractor.
// Reset: rst, synchronous and active high, returns the sequencer to idle.
`default_nettype none
module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], days_to_add[38:23]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // end_year[13:0], end_month[17:14], end_day[22:18]
  output logic [23:0]      m_tdata,
  // status[0]
  output logic [0:0]       m_tuser
);

  ctl_t  ctl;
  stat_t st;

  logic [13:0]       year;
  logic [3:0]        month;
  logic [4:0]        day;
  logic [15:0]       add;
  logic [ORD_W-1:0]  ord;
  logic [CENT_W-1:0] cent;
  logic [CENT_W-1:0] yic;
  logic              sat;

  logic [13:0]       in_year;
  logic [3:0]        in_month;
  logic [26:0]       prod;
  logic [13:0]       cent_x100;
  logic              leap;
  logic [4:0]        mlen;
  logic [4:0]        day_clamp;
  logic [8:0]        sub_b;
  logic [ORD_W-1:0]  sub_diff;
  logic              sub_gt;

  // Clamp a zero year to 1 and the request's month into 1 to 12.
  always_comb begin
    in_year  = s_tdata[13:0];
    in_month = s_tdata[17:14];
    if (in_year == 14'd0) begin
      in_year = 14'd1;
    end
    if (in_month == 4'd0) begin
      in_month = 4'd1;
    end else if (in_month > LAST_MONTH) begin
      in_month = LAST_MONTH;
    end
  end

  // Century and year within century, then the leap flag of the current year.
  assign prod      = {13'd0, year} * {14'd0, RECIP_100};
  assign cent_x100 = {7'd0, cent} * 14'd100;
  assign leap      = (year[1:0] == 2'd0) && ((yic != '0) || (cent[1:0] == 2'd0));

  // Start day clamped to the month's length.
  always_comb begin
    mlen      = month_days(leap, month);
    day_clamp = day;
    if (day_clamp == 5'd0) begin
      day_clamp = 5'd1;
    end else if (day_clamp > mlen) begin
      day_clamp = mlen;
    end
  end

  // Shared subtractor: year length in the year walk, month length after it.
  assign sub_b = ctl.use_year ? (leap ? LEAP_YEAR_LEN : YEAR_LEN)
                              : {4'd0, mlen};

  gdad_sub u_sub (
    .a    (ord),
    .b    (sub_b),
    .diff (sub_diff),
    .gt   (sub_gt)
  );

  assign st.in_fire    = s_tvalid && s_tready;
  assign st.out_fire   = m_tvalid && m_tready;
  assign st.in_over    = s_tdata[13:0] > MAX_YEAR;
  assign st.gt         = sub_gt;
  assign st.year_max   = year == MAX_YEAR;
  assign st.month_last = month == LAST_MONTH;

  gdad_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  // Working registers, each updated on its sequencer command.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      year  <= in_year;
      month <= in_month;
      day   <= s_tdata[22:18];
      add   <= s_tdata[38:23];
      sat   <= st.in_over;
    end
    if (ctl.div) begin
      cent <= prod[RECIP_SHIFT+CENT_W-1:RECIP_SHIFT];
    end
    if (ctl.rem) begin
      yic <= 7'(year - cent_x100);
    end
    if (ctl.ord) begin
      ord <= ORD_W'(days_before(month)) + ORD_W'(day_clamp)
           + ORD_W'(leap && (month > 4'd2)) + ORD_W'(add);
    end
    if (ctl.year_step) begin
      ord  <= sub_diff;
      year <= year + 14'd1;
      if (yic == LAST_YEAR_IN_CENT) begin
        yic  <= '0;
        cent <= cent + 7'd1;
      end else begin
        yic <= yic + 7'd1;
      end
    end
    if (ctl.set_sat) begin
      sat <= 1'b1;
    end
    if (ctl.mon_init) begin
      month <= 4'd1;
    end
    if (ctl.mon_step) begin
      ord   <= sub_diff;
      month <= month + 4'd1;
    end
  end

  // Result, saturated on overflow.
  assign s_tready   = ctl.in_ready;
  assign m_tvalid   = ctl.out_valid;
  assign m_tdata    = sat ? {1'b0, LAST_DAY, LAST_MONTH, MAX_YEAR}
                          : {1'b0, ord[4:0], month, year};
  assign m_tuser[0] = sat;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[13:0] == MAX_YEAR && m_tdata[17:14] == LAST_MONTH
       && m_tdata[22:18] == LAST_DAY))
    else $error("overflow result not saturated");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("still ready right after a request");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |->
      (m_tdata[17:14] != 4'd0 && m_tdata[17:14] <= LAST_MONTH
       && m_tdata[22:18] != 5'd0 && m_tdata[13:0] != 14'd0))
    else $error("result date out of range");

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench
  import gdad_pkg::*;
();

  localparam int LIMIT_CYCLES = 3000000;
  localparam int ITEMS_PER_PHASE = 420;
  localparam int DRAIN_CYCLES = 250;
  localparam int MAX_PRINTED = 40;

  // One calendar date as the block reports it.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        saturated;
  } date_t;

  // Holds the predicted dates in request order and checks the results against them.
  class date_scoreboard;
    date_t expected_dates[$];
    int    n_requests;
    int    n_results;
    int    n_saturated;
    int    n_mismatches;

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned month_length(int unsigned y, int unsigned m);
      case (m)
        4, 6, 9, 11: return 30;
        2:           return leap_year(y) ? 29 : 28;
        default:     return 31;
      endcase
    endfunction

    // Works out the date a request should give, clamping out-of-range fields first.
    function date_t date_after(logic [39:0] req);
      int unsigned year;
      int unsigned month;
      int unsigned day;
      int unsigned ord;
      int unsigned span;
      date_t       res;
      res = '{MAX_YEAR, LAST_MONTH, LAST_DAY, 1'b1};
      year = 32'(req[13:0]);
      month = 32'(req[17:14]);
      day = 32'(req[22:18]);
      if (year == 0) year = 1;
      if (year > MAX_YEAR) return res;
      if (month == 0) month = 1;
      if (month > 12) month = 12;
      if (day == 0) day = 1;
      if (day > month_length(year, month)) day = month_length(year, month);
      // Day of the year, counted from one, then moved forward.
      ord = day;
      for (int unsigned m = 1; m < month; m++) ord += month_length(year, m);
      ord += 32'(req[38:23]);
      // Skip whole years, each at its own length.
      span = leap_year(year) ? 366 : 365;
      while (ord > span) begin
        ord -= span;
        year++;
        if (year > MAX_YEAR) return res;
        span = leap_year(year) ? 366 : 365;
      end
      // Then walk through the months of the final year.
      month = 1;
      while (month < 12 && ord > month_length(year, month)) begin
        ord -= month_length(year, month);
        month++;
      end
      res.year = 14'(year);
      res.month = 4'(month);
      res.day = 5'(ord);
      res.saturated = 1'b0;
      return res;
    endfunction

    function void note_request(logic [39:0] req);
      date_t d;
      d = date_after(req);
      expected_dates.push_back(d);
      n_requests++;
      if (d.saturated) n_saturated++;
    endfunction

    task report_mismatch(string what);
      if (n_mismatches < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, what);
      n_mismatches++;
    endtask

    task check_result(logic [23:0] data, logic status);
      date_t want;
      n_results++;
      if (expected_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d with no request outstanding",
                                  data[13:0], data[17:14], data[22:18]));
      end else begin
        want = expected_dates.pop_front();
        if (data[13:0] !== want.year)
          report_mismatch($sformatf("end_year %0d, expected %0d", data[13:0], want.year));
        if (data[17:14] !== want.month)
          report_mismatch($sformatf("end_month %0d, expected %0d", data[17:14], want.month));
        if (data[22:18] !== want.day)
          report_mismatch($sformatf("end_day %0d, expected %0d", data[22:18], want.day));
        if (status !== want.saturated)
          report_mismatch($sformatf("status %0b, expected %0b", status, want.saturated));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;

  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    n_cycles = 0;
  date_scoreboard sb = new;

  gregorian_date_add_days DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", n_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // The result side stalls at the rate set for the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watch both handshakes; requests are noted before results are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end
  end

  function automatic logic [39:0] pack_request(int unsigned year, int unsigned month,
                                               int unsigned day, int unsigned add);
    return {1'b0, add[15:0], day[4:0], month[3:0], year[13:0]};
  endfunction

  // Mostly valid dates with assorted offsets; some near the top of the range, some noise.
  function automatic logic [39:0] random_request();
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned add;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick >= 88) return {1'b0, 39'($urandom()) ^ {7'd0, 32'($urandom())}};
    case ($urandom_range(0, 5))
      0:       year = $urandom_range(9800, 9999);
      1:       year = $urandom_range(1, 40);
      default: year = $urandom_range(1, 9999);
    endcase
    month = $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) day = sb.month_length(year, month);
    else day = $urandom_range(1, sb.month_length(year, month));
    case ($urandom_range(0, 4))
      0, 1:    add = $urandom_range(0, 65535);
      2:       add = $urandom_range(0, 800);
      3:       add = $urandom_range(0, 40);
      default: add = 365 * $urandom_range(1, 170) + $urandom_range(0, 2);
    endcase
    if (add > 65535) add = 65535;
    // A small share of valid-looking dates carry a clamped month or day.
    if (pick >= 80) begin
      if ($urandom_range(0, 1)) month = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
      else day = $urandom_range(0, 1) ? 0 : $urandom_range(29, 31);
    end
    return pack_request(year, month, day, add);
  endfunction

  // Offers one request, with idle cycles first at the sender's current rate.
  task automatic send_request(input logic [39:0] req);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering requests and waits until every result is in.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (ITEMS_PER_PHASE) send_request(random_request());
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: range ends, clamped fields, leap rules and overflow.
    send_request(pack_request(1, 1, 1, 0));
    send_request(pack_request(9999, 12, 31, 0));
    send_request(pack_request(9999, 12, 31, 1));
    send_request(pack_request(9999, 12, 31, 65535));
    send_request(pack_request(0, 1, 1, 0));
    send_request(pack_request(10000, 6, 15, 0));
    send_request(pack_request(16383, 15, 31, 65535));
    send_request(pack_request(2021, 0, 10, 5));
    send_request(pack_request(2021, 13, 10, 5));
    send_request(pack_request(2021, 15, 31, 0));
    send_request(pack_request(2021, 5, 0, 0));
    send_request(pack_request(2000, 2, 31, 0));
    send_request(pack_request(1900, 2, 31, 0));
    send_request(pack_request(2023, 4, 31, 0));
    send_request(pack_request(2000, 2, 28, 1));
    send_request(pack_request(1900, 2, 28, 1));
    send_request(pack_request(2100, 2, 28, 1));
    send_request(pack_request(2400, 2, 28, 1));
    send_request(pack_request(2023, 3, 1, 365));
    send_request(pack_request(2023, 12, 31, 1));
    send_request(pack_request(2024, 1, 1, 366));
    send_request(pack_request(1, 1, 1, 65535));
    send_request(pack_request(9820, 6, 1, 65535));
    send_request(pack_request(9820, 12, 31, 65535));
    drain_results();

    // Random: free flow, sparse requests, held-back results, then both.
    run_phase(0, 0);
    run_phase(65, 0);
    run_phase(0, 65);
    run_phase(13, 13);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.expected_dates.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_dates.size()));
    $display("Checked %0d results for %0d requests, %0d of them saturated at year 9999.",
             sb.n_results, sb.n_requests, sb.n_saturated);
    $display("Handshakes ran free, with sparse requests, with held-back results and both.");
    if (sb.n_mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.n_mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
